FILE: rtl/quadrant_box_downscale_2x2_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrant box downscaler
// Concurrent checks clocked on clk_i, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef QUADRANT_BOX_DOWNSCALE_2X2_UNIT_MACROS_SVH
`define QUADRANT_BOX_DOWNSCALE_2X2_UNIT_MACROS_SVH

// Check outside reset only
`define QBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included
`define QBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/qbd_pkg.sv
// ----------------------------------------------------------------------------
// qbd_pkg
// Shared constants, types and helpers of the 2x2 box downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package qbd_pkg;

  localparam int MAX_TILE_WIDTH  = 256;
  localparam int MAX_TILE_HEIGHT = 256;
  localparam int LINE_DEPTH      = MAX_TILE_WIDTH / 2;

  localparam int TW_W  = $clog2(MAX_TILE_WIDTH + 1);
  localparam int TH_W  = $clog2(MAX_TILE_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_TILE_WIDTH);
  localparam int ROW_W = $clog2(MAX_TILE_HEIGHT);
  localparam int IDX_W = $clog2(LINE_DEPTH);

  localparam int SIZE_REG_W = 9;
  localparam int QUAD_W     = 2;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int RGB_W      = NUM_CH * CH_W;
  localparam int PSUM_W     = CH_W + 1;
  localparam int TSUM_W     = CH_W + 2;
  localparam int LINE_W     = NUM_CH * TSUM_W;
  localparam int COORD_W    = 8;
  localparam int XW         = (TW_W > COORD_W) ? TW_W : COORD_W;
  localparam int YW         = (TH_W > COORD_W) ? TH_W : COORD_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_WIDTH,
    CFG_TILE_HEIGHT,
    CFG_PAD_RGB,
    CFG_PADDING_ON
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PAIR,
    CMD_AVG,
    CMD_PAD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [RGB_W-1:0]     pix;
    logic [IDX_W-1:0]     idx;
    logic [COORD_W-1:0]   ox;
    logic [COORD_W-1:0]   oy;
    logic                 done;
  } cmd_t;

  function automatic logic [TW_W-1:0] clamp_width(input logic [SIZE_REG_W-1:0] v);
    logic [SIZE_REG_W-1:0] e;
    logic [TW_W-1:0]       r;
    e = {v[SIZE_REG_W-1:1], 1'b0};
    if (e < SIZE_REG_W'(2)) e = SIZE_REG_W'(2);
    if (32'(e) > 32'(MAX_TILE_WIDTH)) r = TW_W'(MAX_TILE_WIDTH);
    else r = TW_W'(e);
    return r;
  endfunction

  function automatic logic [TH_W-1:0] clamp_height(input logic [SIZE_REG_W-1:0] v);
    logic [SIZE_REG_W-1:0] e;
    logic [TH_W-1:0]       r;
    e = {v[SIZE_REG_W-1:1], 1'b0};
    if (e < SIZE_REG_W'(2)) e = SIZE_REG_W'(2);
    if (32'(e) > 32'(MAX_TILE_HEIGHT)) r = TH_W'(MAX_TILE_HEIGHT);
    else r = TH_W'(e);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qbd_in_if.sv
// ----------------------------------------------------------------------------
// qbd_in_if
// Source pixel channel: valid/ready with quadrant tag, absent flag and RGB.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbd_in_if import qbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [QUAD_W-1:0] quadrant;
  logic              absent;
  logic [CH_W-1:0]   in_red;
  logic [CH_W-1:0]   in_green;
  logic [CH_W-1:0]   in_blue;

  modport source (output valid, quadrant, absent, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, quadrant, absent, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/qbd_out_if.sv
// ----------------------------------------------------------------------------
// qbd_out_if
// Result pixel channel: valid/ready with colour, output position and done flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface qbd_out_if import qbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_blue;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               quadrant_done;

  modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                  quadrant_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row,
                  quadrant_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/qbd_ram.sv
// ----------------------------------------------------------------------------
// qbd_ram
// Generic single-write, single-read RAM; read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module qbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/qbd_front.sv
// ----------------------------------------------------------------------------
// qbd_front
// Tracks the source position and turns each pixel into a back-end command.
// ----------------------------------------------------------------------------
`default_nettype none

module qbd_front import qbd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  qbd_in_if.sink          in_ch,
  input  logic [TW_W-1:0] width_i,
  input  logic [TH_W-1:0] height_i,
  input  logic            padding_on_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [TW_W-1:0]  col_p1;
  logic [TH_W-1:0]  row_p1;
  logic             last_col, last_row;
  logic             accept;
  logic             drop;
  logic [IDX_W-1:0] idx;
  logic [XW-1:0]    ox_wide;
  logic [YW-1:0]    oy_wide;

  assign in_ch.ready = !fifo_full_i;
  assign accept      = in_ch.valid && !fifo_full_i;

  assign col_p1   = TW_W'(col_q) + TW_W'(1);
  assign row_p1   = TH_W'(row_q) + TH_W'(1);
  assign last_col = (col_p1 >= width_i);
  assign last_row = (row_p1 >= height_i);

  assign idx     = IDX_W'(col_q >> 1);
  assign ox_wide = (in_ch.quadrant[0] ? XW'(width_i >> 1) : XW'(0)) + XW'(idx);
  assign oy_wide = (in_ch.quadrant[1] ? YW'(height_i >> 1) : YW'(0)) + YW'(row_q >> 1);

  // Classify by position parity; absent blocks become padding or nothing
  always_comb begin
    drop         = 1'b0;
    cmd_o.kind   = CMD_HOLD;
    cmd_o.pix    = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    cmd_o.idx    = idx;
    cmd_o.ox     = COORD_W'(ox_wide);
    cmd_o.oy     = COORD_W'(oy_wide);
    cmd_o.done   = last_col && last_row;
    if (!col_q[0]) begin
      cmd_o.kind = CMD_HOLD;
    end else if (!row_q[0]) begin
      cmd_o.kind = CMD_PAIR;
    end else if (in_ch.absent) begin
      cmd_o.kind = CMD_PAD;
      drop       = !padding_on_i;
    end else begin
      cmd_o.kind = CMD_AVG;
    end
  end

  assign push_o = accept && !drop;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : ROW_W'(row_p1);
      end else begin
        col_d = COL_W'(col_p1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qbd_fifo.sv
// ----------------------------------------------------------------------------
// qbd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrant_box_downscale_2x2_unit_macros.svh"

module qbd_fifo import qbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  cmd_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_PTR_W'(1);
      if (pop_i)  rd_q <= rd_q + FIFO_PTR_W'(1);
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
    end
  end

  `QBD_ASSERT(a_fifo_cnt_bound, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue count too large")
  `QBD_ASSERT(a_fifo_no_underflow, pop_i |-> cnt_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/qbd_back.sv
// ----------------------------------------------------------------------------
// qbd_back
// Executes commands: holds pixels, writes pair sums, averages and emits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrant_box_downscale_2x2_unit_macros.svh"

module qbd_back import qbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  cmd_t             head_i,
  output logic             pop_o,
  input  logic [RGB_W-1:0] pad_rgb_i,
  qbd_out_if.source        out_ch
);

  logic [RGB_W-1:0]  held_q;
  logic              is_emit;
  logic              out_free, b_ready;
  logic              ram_we, ram_re;
  logic [LINE_W-1:0] pair_word;
  logic [LINE_W-1:0] ram_rdata;
  logic [PSUM_W-1:0] cur_sum [NUM_CH];

  logic              b_valid_q, b_valid_d;
  logic              b_pad_q;
  logic [PSUM_W-1:0] b_sum_q [NUM_CH];
  logic [COORD_W-1:0] b_ox_q, b_oy_q;
  logic              b_done_q;

  logic              out_valid_q, out_valid_d;
  logic [RGB_W-1:0]  out_rgb_q, out_rgb_d;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic              out_done_q;

  assign is_emit  = (head_i.kind == CMD_AVG) || (head_i.kind == CMD_PAD);
  assign out_free = !out_valid_q || out_ch.ready;
  assign b_ready  = !b_valid_q || out_free;
  assign pop_o    = head_valid_i && (!is_emit || b_ready);
  assign ram_we   = pop_o && (head_i.kind == CMD_PAIR);
  assign ram_re   = pop_o && (head_i.kind == CMD_AVG);

  // Horizontal sum of the held even-column pixel and the current pixel
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      cur_sum[c] = PSUM_W'(held_q[c*CH_W +: CH_W]) + PSUM_W'(head_i.pix[c*CH_W +: CH_W]);
      pair_word[c*TSUM_W +: TSUM_W] = TSUM_W'(cur_sum[c]);
    end
  end

  qbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.idx),
    .wdata_i (pair_word),
    .re_i    (ram_re),
    .raddr_i (head_i.idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (pop_o && (head_i.kind == CMD_HOLD)) begin
      held_q <= head_i.pix;
    end
  end

  // Stage B: waits on the line buffer read
  always_comb begin
    b_valid_d = b_valid_q;
    if (pop_o && is_emit) begin
      b_valid_d = 1'b1;
    end else if (out_free) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_emit) begin
      b_pad_q  <= (head_i.kind == CMD_PAD);
      b_sum_q  <= cur_sum;
      b_ox_q   <= head_i.ox;
      b_oy_q   <= head_i.oy;
      b_done_q <= head_i.done;
    end
  end

  // Finish the 2x2 sum and truncate by four
  always_comb begin
    logic [TSUM_W-1:0] tot;
    tot       = '0;
    out_rgb_d = pad_rgb_i;
    if (!b_pad_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        tot = ram_rdata[c*TSUM_W +: TSUM_W] + TSUM_W'(b_sum_q[c]);
        out_rgb_d[c*CH_W +: CH_W] = tot[TSUM_W-1:2];
      end
    end
  end

  assign out_valid_d = out_free ? b_valid_q : 1'b1;

  always_ff @(posedge clk_i) begin
    if (out_free && b_valid_q) begin
      out_rgb_q  <= out_rgb_d;
      out_col_q  <= b_ox_q;
      out_row_q  <= b_oy_q;
      out_done_q <= b_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.out_red       = out_rgb_q[2*CH_W +: CH_W];
  assign out_ch.out_green     = out_rgb_q[CH_W +: CH_W];
  assign out_ch.out_blue      = out_rgb_q[0 +: CH_W];
  assign out_ch.out_col       = out_col_q;
  assign out_ch.out_row       = out_row_q;
  assign out_ch.quadrant_done = out_done_q;

  `QBD_ASSERT(a_emit_loads_b, (pop_o && is_emit) |=> b_valid_q, "emit command lost in stage B")
  `QBD_ASSERT(a_out_from_b, $rose(out_valid_q) |-> $past(b_valid_q), "result without stage B")
  `QBD_ASSERT(a_b_blocks_pop, (b_valid_q && !out_free && head_valid_i && is_emit) |-> !pop_o,
              "emit popped while stage B stalled")

endmodule

`default_nettype wire

FILE: rtl/quadrant_box_downscale_2x2_unit.sv
// ----------------------------------------------------------------------------
// quadrant_box_downscale_2x2_unit
// 2x2 box-filter downscaler placing each sub-tile into a half-size quadrant.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries source pixels of one sub-tile in raster order, tagged with
//   the quadrant and an absent flag; out_ch carries averaged pixels with their
//   position in the output tile and a done flag on the last pixel of a quadrant.
//   Every pixel takes one input slot; one result leaves per completed 2x2 block
//   (odd row, odd column), or, with padding on, a padding pixel there for absent sub-tiles.
//   Throughput: one input item per cycle while out_ch keeps up; the back end
//   executes one command per cycle unless an emit waits on a stalled stage B.
//   A finished block goes from the queue through stage B, which reads the line
//   buffer, into the output register before it is offered on out_ch.
//   Reset clears the source position, the queue and all valid flags; the line
//   buffer needs no clearing, each entry is written on an even row before the
//   odd row reads it. Configuration defaults to 256x256, padding off.
//   When out_ch stalls, the output register and stage B hold, the two-entry
//   queue fills and in_ch.ready drops; items that emit nothing keep flowing
//   while room remains in the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrant_box_downscale_2x2_unit import qbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qbd_in_if.sink                in_ch,
  qbd_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SIZE_REG_W-1:0] tile_width_q, tile_height_q;
  logic [RGB_W-1:0]      pad_rgb_q;
  logic                  padding_on_q;
  logic [TW_W-1:0]       width_eff;
  logic [TH_W-1:0]       height_eff;

  logic fifo_full, push, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q  <= SIZE_REG_W'(256);
      tile_height_q <= SIZE_REG_W'(256);
      pad_rgb_q     <= '0;
      padding_on_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TILE_WIDTH:  tile_width_q  <= cfg_data_i[SIZE_REG_W-1:0];
        CFG_TILE_HEIGHT: tile_height_q <= cfg_data_i[SIZE_REG_W-1:0];
        CFG_PAD_RGB:     pad_rgb_q     <= cfg_data_i[RGB_W-1:0];
        CFG_PADDING_ON:  padding_on_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_width(tile_width_q);
  assign height_eff = clamp_height(tile_height_q);

  qbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .padding_on_i (padding_on_q),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  qbd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  qbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .pad_rgb_i    (pad_rgb_q),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 box downscaler. Source pixels are streamed
// through a valid/ready driver while a predictor tracks the line buffer,
// the held pixel and the raster position. Each accepted result is checked
// field by field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qbd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [QUAD_W-1:0] quad;
    logic              absent;
    logic [RGB_W-1:0]  rgb;
  } src_px_t;

  typedef struct packed {
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               done;
  } dst_px_t;

  typedef enum int {TILE_PRESENT, TILE_ABSENT, TILE_MIXED} tile_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic    drv_valid = 1'b0;
  src_px_t drv_pix   = '0;
  logic    sink_rdy  = 1'b0;

  qbd_in_if  in_ch ();
  qbd_out_if out_ch ();

  assign in_ch.valid    = drv_valid;
  assign in_ch.quadrant = drv_pix.quad;
  assign in_ch.absent   = drv_pix.absent;
  assign in_ch.in_red   = drv_pix.rgb[23:16];
  assign in_ch.in_green = drv_pix.rgb[15:8];
  assign in_ch.in_blue  = drv_pix.rgb[7:0];
  assign out_ch.ready   = sink_rdy;

  quadrant_box_downscale_2x2_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [SIZE_REG_W-1:0] cfg_width  = SIZE_REG_W'(256);
  logic [SIZE_REG_W-1:0] cfg_height = SIZE_REG_W'(256);
  logic [RGB_W-1:0]      cfg_pad    = '0;
  logic                  cfg_pad_on = 1'b0;
  logic [LINE_W-1:0]     line_sum [LINE_DEPTH];
  logic [RGB_W-1:0]      held_rgb   = '0;
  int                    pos_col    = 0;
  int                    pos_row    = 0;

  src_px_t src_px_q [$];
  dst_px_t downscaled_q [$];
  int      pushed_n    = 0;
  int      accepted_n  = 0;
  int      err_n       = 0;
  int      cycle_n     = 0;
  int      tx_idle_pct = 10;
  int      rx_idle_pct = 61;

  function automatic int fold_size(input logic [SIZE_REG_W-1:0] raw, input int max_size);
    int v;
    v = int'(raw) & ~1;
    if (v < 2) v = 2;
    if (v > max_size) v = max_size;
    return v;
  endfunction

  function automatic void downscale_step(input src_px_t p);
    int          w, h, idx;
    bit          last_c, last_r;
    logic [9:0]  sr, sg, sb;
    logic [29:0] ps;
    logic [23:0] colour;
    dst_px_t     o;
    w      = fold_size(cfg_width, MAX_TILE_WIDTH);
    h      = fold_size(cfg_height, MAX_TILE_HEIGHT);
    idx    = pos_col >> 1;
    last_c = (pos_col + 1 >= w);
    last_r = (pos_row + 1 >= h);
    if (pos_col % 2 == 0) begin
      held_rgb = p.rgb;
    end else if (pos_row % 2 == 0) begin
      sr = 10'(held_rgb[23:16]) + 10'(p.rgb[23:16]);
      sg = 10'(held_rgb[15:8]) + 10'(p.rgb[15:8]);
      sb = 10'(held_rgb[7:0]) + 10'(p.rgb[7:0]);
      line_sum[idx] = {sr, sg, sb};
    end else begin
      if (p.absent) begin
        colour = cfg_pad;
      end else begin
        ps     = line_sum[idx];
        sr     = ps[29:20] + 10'(held_rgb[23:16]) + 10'(p.rgb[23:16]);
        sg     = ps[19:10] + 10'(held_rgb[15:8]) + 10'(p.rgb[15:8]);
        sb     = ps[9:0] + 10'(held_rgb[7:0]) + 10'(p.rgb[7:0]);
        colour = {sr[9:2], sg[9:2], sb[9:2]};
      end
      if (!p.absent || cfg_pad_on) begin
        o.red   = colour[23:16];
        o.green = colour[15:8];
        o.blue  = colour[7:0];
        o.col   = COORD_W'((p.quad[0] ? w / 2 : 0) + idx);
        o.row   = COORD_W'((p.quad[1] ? h / 2 : 0) + pos_row / 2);
        o.done  = last_c && last_r;
        downscaled_q.push_back(o);
      end
    end
    if (last_c) begin
      pos_col = 0;
      pos_row = last_r ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      err_n++;
    end
  endfunction

  // Driver: hold valid until the item is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && in_ch.ready) begin
        downscale_step(drv_pix);
        accepted_n++;
      end
      if (!drv_valid || in_ch.ready) begin
        if (src_px_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          drv_pix   <= src_px_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    dst_px_t got, want;
    if (rst_ni) begin
      if (out_ch.valid && sink_rdy) begin
        got = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                out_ch.out_col, out_ch.out_row, out_ch.quadrant_done};
        if (downscaled_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          err_n++;
        end else begin
          want = downscaled_q.pop_front();
          cmp_field("red", want.red, got.red);
          cmp_field("green", want.green, got.green);
          cmp_field("blue", want.blue, got.blue);
          cmp_field("col", want.col, got.col);
          cmp_field("row", want.row, got.row);
          cmp_field("done", 8'(want.done), 8'(got.done));
        end
      end
      sink_rdy <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [RGB_W-1:0] rand_pad();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return RGB_W'($urandom);
    endcase
  endfunction

  task automatic queue_px(input int quad, input bit absent, input logic [RGB_W-1:0] rgb);
    src_px_t p;
    p.quad   = QUAD_W'(quad);
    p.absent = absent;
    p.rgb    = rgb;
    src_px_q.push_back(p);
    pushed_n++;
  endtask

  task automatic queue_run(input int n, input int quad, input tile_kind_e kind);
    for (int i = 0; i < n; i++) begin
      case (kind)
        TILE_PRESENT: queue_px(quad, 1'b0, {rand_chan(), rand_chan(), rand_chan()});
        TILE_ABSENT:  queue_px(quad, 1'b1, {rand_chan(), rand_chan(), rand_chan()});
        default: queue_px(int'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          {rand_chan(), rand_chan(), rand_chan()});
      endcase
    end
  endtask

  // Wait until every item is taken and every result has come, then let the
  // pipeline run dry.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_n != pushed_n || downscaled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      CFG_TILE_WIDTH:  cfg_width  = val[SIZE_REG_W-1:0];
      CFG_TILE_HEIGHT: cfg_height = val[SIZE_REG_W-1:0];
      CFG_PAD_RGB:     cfg_pad    = val[RGB_W-1:0];
      CFG_PADDING_ON:  cfg_pad_on = val[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setup(input int w_raw, input int h_raw,
                             input logic [RGB_W-1:0] pad, input bit pad_on);
    cfg_write(CFG_TILE_WIDTH, CFG_DATA_W'(w_raw));
    cfg_write(CFG_TILE_HEIGHT, CFG_DATA_W'(h_raw));
    cfg_write(CFG_PAD_RGB, CFG_DATA_W'(pad));
    cfg_write(CFG_PADDING_ON, CFG_DATA_W'(pad_on));
  endtask

  initial begin
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_n++;
    end
    $display("FAIL quadrant_box_downscale_2x2_unit");
    $finish;
  end

  initial begin
    int         w, h, n;
    tile_kind_e kind;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Odd width and undersized height both fold to 2x2.
    apply_setup(3, 1, 24'hFFFFFF, 1'b1);
    repeat (4) queue_px(0, 1'b0, 24'hFFFFFF);
    repeat (4) queue_px(1, 1'b0, 24'h000000);
    repeat (3) queue_px(2, 1'b0, 24'h010203);
    queue_px(2, 1'b0, 24'h020304);
    // absent sub-tile, padded
    repeat (4) queue_px(3, 1'b1, 24'h5AA55A);
    wait_idle();
    apply_setup(2, 2, 24'h000000, 1'b0);
    // tags change inside the tile; the last item decides the result
    queue_px(0, 1'b0, 24'hAA55AA);
    queue_px(1, 1'b1, 24'h55AA55);
    queue_px(2, 1'b0, 24'hFF00FF);
    queue_px(3, 1'b0, 24'h00FF00);
    // absent with padding off gives nothing
    queue_px(3, 1'b0, 24'h123456);
    queue_px(2, 1'b0, 24'h789ABC);
    queue_px(1, 1'b1, 24'hFEDCBA);
    queue_px(0, 1'b1, 24'h987654);
    wait_idle();

    // Narrow the width in the middle of a tile.
    apply_setup(8, 4, rand_pad(), 1'b1);
    queue_run(10, 1, TILE_PRESENT);
    wait_idle();
    cfg_write(CFG_TILE_WIDTH, CFG_DATA_W'(2));
    queue_run(5, 3, TILE_PRESENT);
    wait_idle();
    // Lower the height in the middle of a tile.
    apply_setup(8, 8, rand_pad(), 1'b0);
    queue_run(27, 2, TILE_PRESENT);
    wait_idle();
    cfg_write(CFG_TILE_HEIGHT, CFG_DATA_W'(2));
    queue_run(5, 2, TILE_PRESENT);
    wait_idle();

    for (int k = 0; k < 12; k++) begin
      if (k == 4) begin
        tx_idle_pct = 61;
        rx_idle_pct = 10;
      end else if (k == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (k == 3) begin
        apply_setup(256 + int'($urandom_range(0, 255)), int'($urandom_range(2, 3)),
                    rand_pad(), 1'($urandom_range(0, 1)));
      end else if (k == 7) begin
        apply_setup(int'($urandom_range(0, 3)), int'($urandom_range(256, 511)),
                    rand_pad(), 1'($urandom_range(0, 1)));
      end else begin
        apply_setup(int'($urandom_range(0, 13)), int'($urandom_range(0, 9)),
                    rand_pad(), 1'($urandom_range(0, 1)));
      end
      w = fold_size(cfg_width, MAX_TILE_WIDTH);
      h = fold_size(cfg_height, MAX_TILE_HEIGHT);
      n = 0;
      do begin
        case ($urandom_range(0, 19))
          0, 1, 2: kind = TILE_ABSENT;
          3, 4, 5: kind = TILE_MIXED;
          default: kind = TILE_PRESENT;
        endcase
        if (k == 3 || k == 7) kind = TILE_MIXED;
        queue_run(w * h, int'($urandom_range(0, 3)), kind);
        n += w * h;
      end while (n < 40);
      // sender holds off until the phase has fully drained
      wait_idle();
    end

    if (err_n == 0) begin
      $display("PASS quadrant_box_downscale_2x2_unit");
    end else begin
      $display("FAIL quadrant_box_downscale_2x2_unit");
    end
    $finish;
  end

endmodule
